[rtl/function_prologue_recognizer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the function prologue recognizer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FUNCTION_PROLOGUE_RECOGNIZER_ASSERT_SVH
`define FUNCTION_PROLOGUE_RECOGNIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent true in the same cycle.
`define FPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Expression must hold in every cycle out of reset.
`define FPR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("invariant check failed");
`else
`define FPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FPR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif
`endif

[rtl/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// Types, instruction patterns and helpers shared by the prologue recognizer.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int unsigned MAX_COUNT_DEFAULT = 1023;

    // Instruction patterns.
    localparam logic [31:0] OR_MOVE_VALUE     = 32'h5800_0000;
    localparam logic [31:0] OR_IMM_MOVE_MASK  = 32'hF800_FFFF;
    localparam logic [31:0] ORR_MOVE_VALUE    = 32'hF400_5800;
    localparam logic [31:0] ORR_MOVE_MASK_A   = 32'hFC1F_FFE0;
    localparam logic [31:0] ORR_MOVE_MASK_B   = 32'hFC00_FFFF;
    localparam logic [31:0] SP_SUB_VALUE      = 32'h67FF_0000;
    localparam logic [31:0] SP_SUB_MASK       = 32'hFFFF_0007;
    localparam logic [31:0] ST_DOUBLE_VALUE   = 32'h201F_0000;
    localparam logic [31:0] ST_MASK           = 32'hFC1F_0000;
    localparam logic [31:0] ST_SINGLE_VALUE   = 32'h241F_0000;
    localparam logic [31:0] FP_ADD_VALUE      = 32'h63DF_0000;
    localparam logic [31:0] FP_ADD_MASK       = 32'hFFFF_0000;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_STORE = 2'd1,
        PH_TRAIL = 2'd2
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [31:0] insn_word;
    } t_in_item;

    typedef struct packed {
        logic        is_save;
        logic [5:0]  saved_reg;
        logic [16:0] save_offset;
        logic [9:0]  words_accepted;
        logic        has_frame;
        logic [15:0] frame_size;
        logic        has_fp;
        logic [15:0] fp_add_imm;
        logic        last;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  word_count;
        logic [15:0] frame_bytes;
        logic        frame_found;
        logic [15:0] fp_immediate;
        logic        fp_found;
    } t_scan_state;

    // Results produced by one decoded word: zero, one or two.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_dec_result;

    function automatic logic is_move(input logic [31:0] w);
        return ((w & OR_IMM_MOVE_MASK) == OR_MOVE_VALUE) ||
               ((w & ORR_MOVE_MASK_A) == ORR_MOVE_VALUE) ||
               ((w & ORR_MOVE_MASK_B) == ORR_MOVE_VALUE);
    endfunction

endpackage

[rtl/fpr_decode.sv]
// ----------------------------------------------------------------------------
// fpr_decode
// Classifies one instruction word against the current scan phase and forms
// the next scan state and the result items it causes.
// ----------------------------------------------------------------------------
module fpr_decode #(
    parameter int unsigned MAX_COUNT = fpr_pkg::MAX_COUNT_DEFAULT
) (
    input  fpr_pkg::t_scan_state i_state,
    input  fpr_pkg::t_in_item    i_item,
    output fpr_pkg::t_scan_state o_next_state,
    output fpr_pkg::t_dec_result o_result
);

    localparam int unsigned COUNT_CAP_INT = (MAX_COUNT < 1023) ? MAX_COUNT : 1023;
    localparam logic [9:0]  COUNT_CAP     = 10'(COUNT_CAP_INT);

    typedef enum logic [2:0] {
        ACT_FINISH,
        ACT_SKIP,
        ACT_SP_SUB,
        ACT_SINGLE,
        ACT_DOUBLE,
        ACT_FP_ADD,
        ACT_STORE_MOVE
    } t_action;

    logic [31:0]         w;
    logic                w_move;
    logic [9:0]          bumped;
    t_action             action;
    fpr_pkg::t_out_item  summary;
    fpr_pkg::t_out_item  save_a;
    fpr_pkg::t_out_item  save_b;

    assign w      = i_item.insn_word;
    assign w_move = fpr_pkg::is_move(w);
    assign bumped = (i_state.word_count < COUNT_CAP) ? i_state.word_count + 10'd1
                                                     : i_state.word_count;

    // Classify the word for the current phase.
    always_comb begin
        action = ACT_FINISH;
        if (!i_item.kind) begin
            unique case (i_state.phase)
                fpr_pkg::PH_LEAD: begin
                    if (w_move) begin
                        action = ACT_SKIP;
                    end else if ((w & fpr_pkg::SP_SUB_MASK) == fpr_pkg::SP_SUB_VALUE) begin
                        action = ACT_SP_SUB;
                    end
                end
                fpr_pkg::PH_STORE: begin
                    if ((w & fpr_pkg::ST_MASK) == fpr_pkg::ST_SINGLE_VALUE) begin
                        action = ACT_SINGLE;
                    end else if ((w & fpr_pkg::ST_MASK) == fpr_pkg::ST_DOUBLE_VALUE) begin
                        action = ACT_DOUBLE;
                    end else if ((w & fpr_pkg::FP_ADD_MASK) == fpr_pkg::FP_ADD_VALUE) begin
                        action = ACT_FP_ADD;
                    end else if (w_move) begin
                        action = ACT_STORE_MOVE;
                    end
                end
                default: begin
                    if (w_move) begin
                        action = ACT_SKIP;
                    end
                end
            endcase
        end
    end

    // Next scan state.
    always_comb begin
        o_next_state = i_state;
        unique case (action)
            ACT_FINISH: begin
                o_next_state.phase        = fpr_pkg::PH_LEAD;
                o_next_state.word_count   = '0;
                o_next_state.frame_bytes  = '0;
                o_next_state.frame_found  = 1'b0;
                o_next_state.fp_immediate = '0;
                o_next_state.fp_found     = 1'b0;
            end
            ACT_SP_SUB: begin
                o_next_state.phase       = fpr_pkg::PH_STORE;
                o_next_state.word_count  = bumped;
                o_next_state.frame_bytes = w[15:0];
                o_next_state.frame_found = 1'b1;
            end
            ACT_FP_ADD: begin
                o_next_state.phase        = fpr_pkg::PH_TRAIL;
                o_next_state.word_count   = bumped;
                o_next_state.fp_immediate = w[15:0];
                o_next_state.fp_found     = 1'b1;
            end
            ACT_STORE_MOVE: begin
                o_next_state.phase      = fpr_pkg::PH_TRAIL;
                o_next_state.word_count = bumped;
            end
            default: begin
                o_next_state.word_count = bumped;
            end
        endcase
    end

    // Result items.
    always_comb begin
        summary                = '0;
        summary.words_accepted = i_state.word_count;
        summary.has_frame      = i_state.frame_found;
        summary.frame_size     = i_state.frame_bytes;
        summary.has_fp         = i_state.fp_found;
        summary.fp_add_imm     = i_state.fp_immediate;
        summary.last           = 1'b1;

        save_a             = '0;
        save_a.is_save     = 1'b1;
        save_a.saved_reg   = {1'b0, w[25:21]};
        save_a.save_offset = {1'b0, w[15:0]};

        save_b             = save_a;
        save_b.saved_reg   = {1'b0, w[25:21]} + 6'd1;
        save_b.save_offset = {1'b0, w[15:0]} + 17'd4;
        save_b.last        = 1'b1;

        o_result        = '0;
        o_result.second = save_b;
        unique case (action)
            ACT_FINISH: begin
                o_result.count = 2'd1;
                o_result.first = summary;
            end
            ACT_SINGLE: begin
                o_result.count      = 2'd1;
                o_result.first      = save_a;
                o_result.first.last = 1'b1;
            end
            ACT_DOUBLE: begin
                o_result.count = 2'd2;
                o_result.first = save_a;
            end
            default: begin
                o_result.count = 2'd0;
                o_result.first = save_a;
            end
        endcase
    end

endmodule

[rtl/function_prologue_recognizer.sv]
// ----------------------------------------------------------------------------
// function_prologue_recognizer
// Scans prologue instruction words and reports saved registers and a frame
// summary at the end of each scan.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  ----------------------------------
//   input     i_in_valid / o_in_ready      i_in_item  (fpr_pkg::t_in_item)
//   output    o_out_valid / i_out_ready    o_out_item (fpr_pkg::t_out_item)
//
// Each accepted request is held in the input register and is decoded in the
// cycle it leaves it, so with an always-ready consumer one request is taken
// per cycle unless a save report is pending. A double store yields two save
// reports; the second sits in a pending register, which holds the input
// register until that report moves on. The single output register sets the
// backpressure point. Reset (synchronous, active low) empties both stages
// and returns the scanner to the leading-moves phase with all counters clear.
// ----------------------------------------------------------------------------
module function_prologue_recognizer #(
    parameter int unsigned MAX_COUNT = fpr_pkg::MAX_COUNT_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fpr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fpr_pkg::t_out_item o_out_item
);

`include "function_prologue_recognizer_assert.svh"

    localparam int unsigned COUNT_CAP_INT = (MAX_COUNT < 1023) ? MAX_COUNT : 1023;

    // Input register.
    logic                 r_in_valid;
    fpr_pkg::t_in_item    r_in;

    // Scan state carried from word to word.
    fpr_pkg::t_scan_state r_state;
    fpr_pkg::t_scan_state n_state;

    // Output register and the pending second report of a double store.
    logic                 r_out_valid;
    fpr_pkg::t_out_item   r_out;
    logic                 r_pend_valid;
    fpr_pkg::t_out_item   r_pend;

    fpr_pkg::t_dec_result dec_result;
    logic                 advance;

    fpr_decode #(
        .MAX_COUNT(MAX_COUNT)
    ) u_decode (
        .i_state      (r_state),
        .i_item       (r_in),
        .o_next_state (n_state),
        .o_result     (dec_result)
    );

    // The held request moves on when no second report is pending and its
    // results, if any, have a free output register to land in.
    assign advance = r_in_valid && !r_pend_valid &&
                     ((dec_result.count == 2'd0) || !r_out_valid || i_out_ready);

    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_state      <= '{phase: fpr_pkg::PH_LEAD, default: '0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && (dec_result.count != 2'd0)) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= (dec_result.count == 2'd2);
            end else if (r_pend_valid && i_out_ready) begin
                r_pend_valid <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance && (dec_result.count != 2'd0)) begin
            r_out  <= dec_result.first;
            r_pend <= dec_result.second;
        end else if (r_pend_valid && i_out_ready) begin
            r_out <= r_pend;
        end
    end

    // A pending report only exists behind a report in the output register.
    `FPR_ASSERT_IMP(a_pend_behind_out, i_clk, i_rst_n, r_pend_valid, r_out_valid)
    // The pending report is always the closing save of a double store.
    `FPR_ASSERT_IMP(a_pend_is_save, i_clk, i_rst_n, r_pend_valid,
                    r_pend.is_save && r_pend.last)
    // A report without the last mark must have its partner waiting.
    `FPR_ASSERT_IMP(a_first_has_partner, i_clk, i_rst_n, r_out_valid && !r_out.last,
                    r_pend_valid)
    // The word counter never passes its saturation value.
    `FPR_ASSERT_ALWAYS(a_count_capped, i_clk, i_rst_n,
                       r_state.word_count <= 10'(COUNT_CAP_INT))

endmodule
